// ===== sv/lsbp_pkg.sv =====
// Shared types and constants for the LSB-first bit packer.
package lsbp_pkg;

  typedef logic [1:0] op_t;

  localparam op_t OP_FIELD  = 2'd0;
  localparam op_t OP_UVARINT = 2'd1;
  localparam op_t OP_SVARINT = 2'd2;
  localparam op_t OP_FLUSH  = 2'd3;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned MAX_RESULTS = 3;
  localparam logic [2:0] BYTES_FULL = 3'd4;
  localparam logic [5:0] WIDTH_MAX = 6'd32;

  // One append request to the shared step unit: the low n bits of bits.
  typedef struct packed {
    logic [31:0] bits;
    logic [5:0]  n;
  } step_req_t;

  // Outcome of one append: a completed word, if any, and the new buffer.
  typedef struct packed {
    logic        emit;
    logic [31:0] word;
    logic [31:0] pending;
    logic [4:0]  fill;
  } step_rsp_t;

endpackage

// ===== sv/lsbp_if.sv =====
// Valid/ready channel interfaces for the packer's input and result items.
interface lsbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] value;
  logic [5:0]  width;

  modport source (output valid, operation, value, width, input ready);
  modport sink   (input valid, operation, value, width, output ready);
endinterface

interface lsbp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic [2:0]  byte_count;
  logic        last;

  modport source (output valid, word, byte_count, last, input ready);
  modport sink   (input valid, word, byte_count, last, output ready);
endinterface

// ===== sv/lsbp_step.sv =====
// Shared shift-and-merge unit that appends up to 32 bits to the bit buffer.
module lsbp_step (
  input  logic              [31:0] pending,
  input  logic              [4:0]  fill,
  input  lsbp_pkg::step_req_t      req,
  output lsbp_pkg::step_rsp_t      rsp
);

  logic [63:0] acc;
  logic [5:0]  fill_sum;

  // Place the new bits just above the pending ones.
  assign acc      = {32'd0, pending} | ({32'd0, req.bits} << fill);
  assign fill_sum = {1'b0, fill} + req.n;

  always_comb begin
    rsp.emit = fill_sum[5];
    rsp.word = acc[31:0];
    rsp.fill = fill_sum[4:0];
    if (fill_sum[5]) begin
      rsp.pending = acc[63:32];
    end else begin
      rsp.pending = acc[31:0];
    end
  end

endmodule

// ===== sv/lsb_first_bit_packer.sv =====
// Top level of the LSB-first bit packer with varint coding.
// Items arrive on req (operation, value, width) and leave on rsp as 32-bit
// words, the earliest stream bit at bit 0, with byte_count valid low bytes
// and last set on the final result that an input item causes.
// The block takes one input item at a time. It is ready only when idle; an
// accepted item then spends its work cycles in one shared append unit that
// merges up to 32 bits into the 32-bit buffer per cycle.
// A field or a flush is worked in one go; a varint is worked byte group by
// byte group, each nonzero group and then the closing zero bit.
// Completed words (at most three per item) gather in a small result queue
// and are offered one per cycle while the receiver is ready, once the work
// is done; the block is ready again in the cycle after the last result is
// taken, or directly after the work when the item causes no result.
// A stalled receiver simply holds the block in its result phase: the
// offered result stays in place until it is taken, and nothing is lost.
// Reset (synchronous, active high) empties the buffer and the queue and
// returns the block to idle.
module lsb_first_bit_packer (
  input  logic       clk,
  input  logic       rst,
  lsbp_in_if.sink    req,
  lsbp_out_if.source rsp
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WORK = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [1:0]  state;
  logic [1:0]  state_next;
  logic [1:0]  op;
  logic [63:0] v;
  logic [5:0]  wsat;
  logic [31:0] pending;
  logic [31:0] pending_next;
  logic [4:0]  fill;
  logic [4:0]  fill_next;

  // Result queue: completed words wait here until the item is finished.
  logic [31:0] q_word  [lsbp_pkg::MAX_RESULTS];
  logic [2:0]  q_bytes [lsbp_pkg::MAX_RESULTS];
  logic [1:0]  cnt;
  logic [1:0]  cnt_next;
  logic [1:0]  rd;

  lsbp_pkg::step_req_t step_req;
  lsbp_pkg::step_rsp_t step_rsp;

  logic        push;
  logic [31:0] push_word;
  logic [2:0]  push_bytes;
  logic        work_done;
  logic        v_zero;
  logic [31:0] field_mask;
  logic [5:0]  width_in;
  logic [31:0] zz_src;
  logic [31:0] zz;
  logic [5:0]  flush_sum;

  lsbp_step u_step (
    .pending (pending),
    .fill    (fill),
    .req     (step_req),
    .rsp     (step_rsp)
  );

  assign req.ready = (state == ST_IDLE);

  // Width saturates at 32; zigzag maps the sign into bit 0.
  assign width_in = (req.width > lsbp_pkg::WIDTH_MAX) ? lsbp_pkg::WIDTH_MAX : req.width;
  assign zz_src   = req.value[31:0];
  assign zz       = {zz_src[30:0], 1'b0} ^ {32{zz_src[31]}};

  assign v_zero     = (v == 64'd0);
  assign field_mask = 32'hFFFF_FFFF >> (lsbp_pkg::WIDTH_MAX - wsat);
  assign flush_sum  = {1'b0, fill} + 6'd7;

  // Sequencer: choose what the shared append unit does this cycle.
  always_comb begin
    step_req     = '0;
    pending_next = pending;
    fill_next    = fill;
    push         = 1'b0;
    push_word    = step_rsp.word;
    push_bytes   = lsbp_pkg::BYTES_FULL;
    work_done    = 1'b0;
    if (state == ST_WORK) begin
      case (op)
        lsbp_pkg::OP_FIELD: begin
          work_done = 1'b1;
          if (wsat != 6'd0) begin
            step_req.bits = v[31:0] & field_mask;
            step_req.n    = wsat;
            pending_next  = step_rsp.pending;
            fill_next     = step_rsp.fill;
            push          = step_rsp.emit;
          end
        end
        lsbp_pkg::OP_UVARINT, lsbp_pkg::OP_SVARINT: begin
          // One group per cycle: a one flag then the low byte; a zero bit ends it.
          if (!v_zero) begin
            step_req.bits = {23'd0, v[7:0], 1'b1};
            step_req.n    = 6'd9;
          end else begin
            step_req.bits = 32'd0;
            step_req.n    = 6'd1;
            work_done     = 1'b1;
          end
          pending_next = step_rsp.pending;
          fill_next    = step_rsp.fill;
          push         = step_rsp.emit;
        end
        default: begin
          work_done = 1'b1;
          if (fill != 5'd0) begin
            push         = 1'b1;
            push_word    = pending;
            push_bytes   = flush_sum[5:3];
            pending_next = 32'd0;
            fill_next    = 5'd0;
          end
        end
      endcase
    end
  end

  assign cnt_next = push ? cnt + 2'd1 : cnt;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          state_next = ST_WORK;
        end
      end
      ST_WORK: begin
        if (work_done) begin
          state_next = (cnt_next != 2'd0) ? ST_SEND : ST_IDLE;
        end
      end
      ST_SEND: begin
        if (rsp.ready && rsp.last) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pending <= 32'd0;
      fill    <= 5'd0;
      cnt     <= 2'd0;
      rd      <= 2'd0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
      fill    <= fill_next;
      if (state == ST_WORK) begin
        cnt <= cnt_next;
      end else if (state == ST_SEND && rsp.ready) begin
        if (rsp.last) begin
          cnt <= 2'd0;
          rd  <= 2'd0;
        end else begin
          rd <= rd + 2'd1;
        end
      end
    end
  end

  // Payload registers: the item under work and the queued results.
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      op   <= req.operation;
      wsat <= width_in;
      if (req.operation == lsbp_pkg::OP_SVARINT) begin
        v <= {32'd0, zz};
      end else begin
        v <= req.value;
      end
    end else if (state == ST_WORK && !v_zero) begin
      v <= v >> 8;
    end
    if (push) begin
      q_word[cnt]  <= push_word;
      q_bytes[cnt] <= push_bytes;
    end
  end

  assign rsp.valid      = (state == ST_SEND);
  assign rsp.word       = q_word[rd];
  assign rsp.byte_count = q_bytes[rd];
  assign rsp.last       = (rd == cnt - 2'd1);

endmodule

// ===== sim/lsbp_stream_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the bit packer: predicts the result words of each accepted item and checks them.
module lsbp_stream_checker (
  input  logic        clk,
  input  logic        rst,
  lsbp_in_if          req,
  lsbp_out_if         rsp,
  output int unsigned mismatch_count,
  output int unsigned words_awaited
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  byte_count;
    logic        last;
  } packed_word_t;

  // Our own copy of the stream buffer: pending bits sit in the low fill positions.
  logic [31:0]  model_bits;
  logic [5:0]   model_fill;
  packed_word_t item_words[$];
  packed_word_t expected_words[$];

  // Appends the low n bits of v (n is 1 to 32) and records a completed word.
  function automatic void append_bits(input logic [63:0] v, input int unsigned n);
    logic [63:0]  mask;
    logic [63:0]  acc;
    packed_word_t full;
    mask = (n >= 32) ? 64'h0000_0000_FFFF_FFFF : ((64'd1 << n) - 64'd1);
    acc = {32'd0, model_bits} | ((v & mask) << model_fill);
    model_fill = model_fill + 6'(n);
    if (model_fill >= 6'(lsbp_pkg::WORD_BITS)) begin
      full.word = acc[31:0];
      full.byte_count = lsbp_pkg::BYTES_FULL;
      full.last = 1'b0;
      item_words.push_back(full);
      acc = acc >> 32;
      model_fill = model_fill - 6'(lsbp_pkg::WORD_BITS);
    end
    model_bits = acc[31:0];
  endfunction

  // Each nonzero remainder gives a set flag and its low byte; a clear bit closes the code.
  function automatic void append_varint(input logic [63:0] v);
    while (v != 64'd0) begin
      append_bits(64'd1, 1);
      append_bits(v & 64'd255, 8);
      v = v >> 8;
    end
    append_bits(64'd0, 1);
  endfunction

  function automatic void predict_words(input lsbp_pkg::op_t op, input logic [63:0] value,
                                        input logic [5:0] width);
    int unsigned  n;
    logic [31:0]  zigzag;
    packed_word_t part;
    item_words.delete();
    case (op)
      lsbp_pkg::OP_FIELD: begin
        n = (width > lsbp_pkg::WIDTH_MAX) ? lsbp_pkg::WORD_BITS : int'(width);
        if (n != 0) append_bits(value, n);
      end
      lsbp_pkg::OP_UVARINT: begin
        append_varint(value);
      end
      lsbp_pkg::OP_SVARINT: begin
        zigzag = {value[30:0], 1'b0} ^ {32{value[31]}};
        append_varint({32'd0, zigzag});
      end
      lsbp_pkg::OP_FLUSH: begin
        if (model_fill != 6'd0) begin
          part.word = model_bits;
          part.byte_count = 3'((int'(model_fill) + 7) / 8);
          part.last = 1'b0;
          item_words.push_back(part);
          model_bits = 32'd0;
          model_fill = 6'd0;
        end
      end
      default: ;
    endcase
    if (item_words.size() != 0) item_words[item_words.size() - 1].last = 1'b1;
    foreach (item_words[i]) expected_words.push_back(item_words[i]);
  endfunction

  always @(posedge clk) begin : monitor
    packed_word_t want;
    if (rst) begin
      model_bits = 32'd0;
      model_fill = 6'd0;
      expected_words.delete();
      mismatch_count = 0;
    end else begin
      // Prediction goes first, so the queue stays in stream order.
      if (req.valid && req.ready) predict_words(req.operation, req.value, req.width);
      if (rsp.valid && rsp.ready) begin
        if (expected_words.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result, expected none, actual word %h bytes %0d last %0b",
                   $time, rsp.word, rsp.byte_count, rsp.last);
        end else begin
          want = expected_words.pop_front();
          if (rsp.word !== want.word) begin
            mismatch_count++;
            $display("%0t: word mismatch, expected %h, actual %h",
                     $time, want.word, rsp.word);
          end
          if (rsp.byte_count !== want.byte_count) begin
            mismatch_count++;
            $display("%0t: byte_count mismatch, expected %0d, actual %0d",
                     $time, want.byte_count, rsp.byte_count);
          end
          if (rsp.last !== want.last) begin
            mismatch_count++;
            $display("%0t: last mismatch, expected %0b, actual %0b",
                     $time, want.last, rsp.last);
          end
        end
      end
    end
    words_awaited = expected_words.size();
  end

endmodule

// ===== sim/tb_lsb_first_bit_packer.sv =====
`timescale 1ns / 1ps
// Top of the bit packer testbench: clock, reset, item stimulus, result sink and the verdict.
module tb_lsb_first_bit_packer;

  // The sender offers about this many random items after the directed part.
  localparam int unsigned RANDOM_ITEMS = 207;
  // The receiver holds off this long, once after each of these many words.
  localparam int unsigned HOLD_CYCLES = 64;
  localparam int unsigned HOLD_AT_FIRST = 25;
  localparam int unsigned HOLD_AT_SECOND = 90;
  // Bound on the wait for outstanding words, and the quiet tail after it.
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 20;

  logic        clk;
  logic        rst;
  // When set, neither side inserts gaps or stalls.
  logic        no_idle;
  int unsigned mismatch_count;
  int unsigned words_awaited;

  lsbp_in_if  req_ch ();
  lsbp_out_if rsp_ch ();

  lsb_first_bit_packer dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  lsbp_stream_checker stream_check (
    .clk            (clk),
    .rst            (rst),
    .req            (req_ch),
    .rsp            (rsp_ch),
    .mismatch_count (mismatch_count),
    .words_awaited  (words_awaited)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // A generous ceiling on the whole run: a correct run needs well under a tenth of it.
  initial begin : watchdog
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Offers one item. Called at a falling edge; returns at the falling edge after the
  // item has been accepted. Valid stays high between back-to-back items, so it is
  // only lowered when a gap is actually drawn.
  task automatic offer_item(input lsbp_pkg::op_t op, input logic [63:0] value,
                            input logic [5:0] width);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.operation = op;
    req_ch.value = value;
    req_ch.width = width;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // One random item. Fields dominate, as in real traffic; varints come with every
  // length of byte group, and a flush now and then closes a partial word.
  task automatic random_item();
    int unsigned pick;
    logic [63:0] value;
    logic [5:0]  width;
    pick = $urandom_range(0, 99);
    value = {$urandom, $urandom};
    width = 6'($urandom_range(0, 63));
    if (pick < 45) begin
      // Mostly legal widths, but zero and oversized widths turn up as well.
      if ($urandom_range(0, 9) != 0) width = 6'($urandom_range(1, 32));
      offer_item(lsbp_pkg::OP_FIELD, value, width);
    end else if (pick < 70) begin
      offer_item(lsbp_pkg::OP_UVARINT, value >> (8 * $urandom_range(0, 8)), width);
    end else if (pick < 88) begin
      // Half of the signed values are small, on either side of zero.
      if ($urandom_range(0, 1) != 0) value[31:0] = 32'($urandom_range(0, 600)) - 32'd300;
      offer_item(lsbp_pkg::OP_SVARINT, value, width);
    end else begin
      offer_item(lsbp_pkg::OP_FLUSH, value, width);
    end
  endtask

  // Result sink. Before each word it draws a stall; twice in the run it holds off
  // for a long stretch while the sender keeps offering, so the block waits in its
  // result phase and stops taking items.
  initial begin : result_sink
    int unsigned stall;
    int unsigned taken;
    rsp_ch.ready = 1'b0;
    taken = 0;
    wait (!rst);
    @(negedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (taken == HOLD_AT_FIRST || taken == HOLD_AT_SECOND) stall = HOLD_CYCLES;
      if (stall != 0) begin
        rsp_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready = 1'b1;
      do @(posedge clk); while (!rsp_ch.valid);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int unsigned drain;
    rst = 1'b1;
    no_idle = 1'b0;
    req_ch.valid = 1'b0;
    req_ch.operation = lsbp_pkg::OP_FIELD;
    req_ch.value = 64'd0;
    req_ch.width = 6'd0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // Directed part. A flush on an empty buffer must give nothing at all.
    offer_item(lsbp_pkg::OP_FLUSH, 64'd0, 6'd0);
    offer_item(lsbp_pkg::OP_FIELD, 64'd1, 6'd1);
    // A full-width field of ones: the upper value bits must be ignored, and the
    // word completes with one bit left over.
    offer_item(lsbp_pkg::OP_FIELD, '1, 6'd32);
    // Zero width writes nothing; widths above 32 behave as 32.
    offer_item(lsbp_pkg::OP_FIELD, {$urandom, $urandom}, 6'd0);
    offer_item(lsbp_pkg::OP_FIELD, {$urandom, $urandom}, 6'd63);
    offer_item(lsbp_pkg::OP_FIELD, {$urandom, $urandom}, 6'd33);
    // A zero varint is a single clear bit.
    offer_item(lsbp_pkg::OP_UVARINT, 64'd0, 6'd0);
    offer_item(lsbp_pkg::OP_FLUSH, 64'd0, 6'd0);
    // One byte, flushed on its own.
    offer_item(lsbp_pkg::OP_FIELD, 64'hA5, 6'd8);
    offer_item(lsbp_pkg::OP_FLUSH, 64'd0, 6'd63);
    // With 31 bits pending, the longest varint completes three words in one item.
    offer_item(lsbp_pkg::OP_FIELD, {$urandom, $urandom}, 6'd31);
    offer_item(lsbp_pkg::OP_UVARINT, '1, 6'd0);
    // Zero byte groups inside a varint still carry a set flag.
    offer_item(lsbp_pkg::OP_UVARINT, 64'h0000_0000_0001_0000, 6'd17);
    // Signed values: zero, minus one, the most negative and the most positive,
    // the last one with junk in the upper half.
    offer_item(lsbp_pkg::OP_SVARINT, 64'd0, 6'd0);
    offer_item(lsbp_pkg::OP_SVARINT, '1, 6'd0);
    offer_item(lsbp_pkg::OP_SVARINT, 64'h0000_0000_8000_0000, 6'd0);
    offer_item(lsbp_pkg::OP_SVARINT, 64'h1234_5678_7FFF_FFFF, 6'd0);
    offer_item(lsbp_pkg::OP_FIELD, 64'd0, 6'd7);
    offer_item(lsbp_pkg::OP_FLUSH, 64'd0, 6'd0);
    // 25 bits flush as four bytes.
    offer_item(lsbp_pkg::OP_FIELD, '1, 6'd25);
    offer_item(lsbp_pkg::OP_FLUSH, '1, 6'd0);
    // An exact word from an empty buffer, so the flush after it finds nothing.
    offer_item(lsbp_pkg::OP_FIELD, {$urandom, $urandom}, 6'd32);
    offer_item(lsbp_pkg::OP_FLUSH, 64'd0, 6'd0);

    // Random part in four stretches; the third runs with no gaps and no stalls.
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      no_idle = ((i * 4) / RANDOM_ITEMS) == 2;
      random_item();
    end
    no_idle = 1'b0;
    req_ch.valid = 1'b0;

    // Wait for every predicted word, then a short tail to catch stray results.
    drain = 0;
    while (words_awaited != 0 && drain < DRAIN_LIMIT) begin
      @(negedge clk);
      drain++;
    end
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && words_awaited == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
